/* design/lpc_pkg.sv */
// ----------------------------------------------------------------------------
// lpc_pkg: shared types, constants and microcode for the parent-climb LCA
// Holds the transfer payload structs, the control word layout and the
// read-only program that the sequencer steps through.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int unsigned IdW   = 10;
  localparam int unsigned Depth = 1 << IdW;
  localparam int unsigned Nodes = 1024;
  localparam int unsigned StepW = $clog2(Nodes + 1);
  localparam int unsigned UpcW  = 4;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic           opcode;
    logic [IdW-1:0] entry_node;
    logic [IdW-1:0] entry_parent;
    logic [IdW-1:0] entry_depth;
    logic [IdW-1:0] query_u;
    logic [IdW-1:0] query_v;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0] ancestor;
    logic           fault;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD_QUERY,
    DP_LOAD_DA,
    DP_SWAP_DIFF,
    DP_CLIMB_A_DIFF,
    DP_CLIMB_A,
    DP_CLIMB_B,
    DP_EMIT_OK,
    DP_EMIT_FAIL
  } dp_op_e;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_CLEARING,
    CND_NO_QUERY,
    CND_A_EQ_B,
    CND_DIFF_ZERO,
    CND_BUDGET,
    CND_OUT_FULL
  } cond_e;

  typedef enum logic {
    SEL_A,
    SEL_B
  } addr_sel_e;

  typedef struct packed {
    dp_op_e          op;
    addr_sel_e       sel;
    cond_e           cond;
    logic [UpcW-1:0] jmp;
    logic [UpcW-1:0] nxt;
  } ctrl_t;

  typedef struct packed {
    logic clearing;
    logic no_query;
    logic a_eq_b;
    logic diff_zero;
    logic budget;
    logic out_full;
  } status_t;

  typedef struct packed {
    logic           we;
    logic [IdW-1:0] waddr;
    logic [IdW-1:0] wparent;
    logic [IdW-1:0] wdepth;
    logic [IdW-1:0] raddr;
  } mem_req_t;

  // program step addresses
  localparam logic [UpcW-1:0] StClr   = 4'd0;
  localparam logic [UpcW-1:0] StIdle  = 4'd1;
  localparam logic [UpcW-1:0] StCmp   = 4'd2;
  localparam logic [UpcW-1:0] StRdB   = 4'd3;
  localparam logic [UpcW-1:0] StSwap  = 4'd4;
  localparam logic [UpcW-1:0] StP1    = 4'd5;
  localparam logic [UpcW-1:0] StC1    = 4'd6;
  localparam logic [UpcW-1:0] StP2    = 4'd7;
  localparam logic [UpcW-1:0] StC2A   = 4'd8;
  localparam logic [UpcW-1:0] StC2B   = 4'd9;
  localparam logic [UpcW-1:0] StEmOk  = 4'd10;
  localparam logic [UpcW-1:0] StEmFl  = 4'd11;

  // next step = cond ? jmp : nxt
  function automatic ctrl_t ucode(input logic [UpcW-1:0] upc);
    ctrl_t w;
    case (upc)
      StClr:  w = '{DP_NOP,          SEL_A, CND_CLEARING,  StClr,  StIdle};
      StIdle: w = '{DP_LOAD_QUERY,   SEL_A, CND_NO_QUERY,  StIdle, StCmp};
      StCmp:  w = '{DP_NOP,          SEL_A, CND_A_EQ_B,    StEmOk, StRdB};
      StRdB:  w = '{DP_LOAD_DA,      SEL_B, CND_NEVER,     StSwap, StSwap};
      StSwap: w = '{DP_SWAP_DIFF,    SEL_A, CND_NEVER,     StP1,   StP1};
      StP1:   w = '{DP_NOP,          SEL_A, CND_DIFF_ZERO, StP2,   StC1};
      StC1:   w = '{DP_CLIMB_A_DIFF, SEL_A, CND_BUDGET,    StEmFl, StP1};
      StP2:   w = '{DP_NOP,          SEL_A, CND_A_EQ_B,    StEmOk, StC2A};
      StC2A:  w = '{DP_CLIMB_A,      SEL_B, CND_BUDGET,    StEmFl, StC2B};
      StC2B:  w = '{DP_CLIMB_B,      SEL_A, CND_BUDGET,    StEmFl, StP2};
      StEmOk: w = '{DP_EMIT_OK,      SEL_A, CND_OUT_FULL,  StEmOk, StIdle};
      StEmFl: w = '{DP_EMIT_FAIL,    SEL_A, CND_OUT_FULL,  StEmFl, StIdle};
      default: w = '{DP_NOP,         SEL_A, CND_NEVER,     StIdle, StIdle};
    endcase
    return w;
  endfunction

endpackage

/* design/lpc_node_mem.sv */
// ----------------------------------------------------------------------------
// lpc_node_mem: parent and depth table storage
// One write and one registered read per cycle; clears itself after reset.
// ----------------------------------------------------------------------------
module lpc_node_mem (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lpc_pkg::mem_req_t      req_i,
  output logic [lpc_pkg::IdW-1:0] rd_parent_o,
  output logic [lpc_pkg::IdW-1:0] rd_depth_o,
  output logic                   clearing_o
);

  logic [lpc_pkg::IdW-1:0] parent_mem [lpc_pkg::Depth];
  logic [lpc_pkg::IdW-1:0] depth_mem  [lpc_pkg::Depth];

  logic [lpc_pkg::IdW:0]   clr_q, clr_d;
  logic                    we;
  logic [lpc_pkg::IdW-1:0] waddr, wparent, wdepth;

  assign clearing_o = !clr_q[lpc_pkg::IdW];

  always_comb begin
    clr_d = clr_q;
    if (clearing_o) begin
      clr_d = clr_q + 1'b1;
    end
  end

  // sweep zeros through both tables until the counter wraps into its top bit
  always_comb begin
    if (clearing_o) begin
      we      = 1'b1;
      waddr   = clr_q[lpc_pkg::IdW-1:0];
      wparent = '0;
      wdepth  = '0;
    end else begin
      we      = req_i.we;
      waddr   = req_i.waddr;
      wparent = req_i.wparent;
      wdepth  = req_i.wdepth;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      parent_mem[waddr] <= wparent;
      depth_mem[waddr]  <= wdepth;
    end
    rd_parent_o <= parent_mem[req_i.raddr];
    rd_depth_o  <= depth_mem[req_i.raddr];
  end

endmodule

/* design/lpc_datapath.sv */
// ----------------------------------------------------------------------------
// lpc_datapath: climb registers, step budget and result register
// Executes one control word per cycle and reports the jump conditions.
// ----------------------------------------------------------------------------
module lpc_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lpc_pkg::ctrl_t          ctrl_i,
  input  logic                    in_valid_i,
  input  lpc_pkg::in_item_t       in_i,
  input  logic                    out_stall_i,
  input  logic [lpc_pkg::IdW-1:0] rd_parent_i,
  input  logic [lpc_pkg::IdW-1:0] rd_depth_i,
  input  logic                    clearing_i,
  output lpc_pkg::mem_req_t       req_o,
  output lpc_pkg::status_t        status_o,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  output lpc_pkg::out_item_t      out_o
);

  logic [lpc_pkg::IdW-1:0]   a_q, a_d, b_q, b_d, da_q, da_d, diff_q, diff_d;
  logic [lpc_pkg::StepW-1:0] steps_q, steps_d;
  logic                      out_valid_q, out_valid_d;
  lpc_pkg::out_item_t        out_q, out_d;
  logic                      in_xfer, budget, out_full;

  assign in_stall_o = (ctrl_i.op != lpc_pkg::DP_LOAD_QUERY);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign budget     = (steps_q >= lpc_pkg::StepW'(lpc_pkg::Nodes));
  assign out_full   = out_valid_q && out_stall_i;

  always_comb begin
    req_o.we      = in_xfer && (in_i.opcode == lpc_pkg::OpWrite) && (in_i.entry_node != '0);
    req_o.waddr   = in_i.entry_node;
    req_o.wparent = in_i.entry_parent;
    req_o.wdepth  = in_i.entry_depth;
    req_o.raddr   = (ctrl_i.sel == lpc_pkg::SEL_B) ? b_q : a_q;
  end

  always_comb begin
    status_o.clearing  = clearing_i;
    status_o.no_query  = !(in_valid_i && (in_i.opcode == lpc_pkg::OpQuery));
    status_o.a_eq_b    = (a_q == b_q);
    status_o.diff_zero = (diff_q == '0);
    status_o.budget    = budget;
    status_o.out_full  = out_full;
  end

  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    da_d        = da_q;
    diff_d      = diff_q;
    steps_d     = steps_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (ctrl_i.op)
      lpc_pkg::DP_LOAD_QUERY: begin
        if (in_xfer && (in_i.opcode == lpc_pkg::OpQuery)) begin
          a_d     = in_i.query_u;
          b_d     = in_i.query_v;
          steps_d = '0;
        end
      end
      lpc_pkg::DP_LOAD_DA: begin
        da_d = rd_depth_i;
      end
      lpc_pkg::DP_SWAP_DIFF: begin
        // keep the deeper node in a
        if (da_q < rd_depth_i) begin
          a_d    = b_q;
          b_d    = a_q;
          diff_d = rd_depth_i - da_q;
        end else begin
          diff_d = da_q - rd_depth_i;
        end
      end
      lpc_pkg::DP_CLIMB_A_DIFF: begin
        if (!budget) begin
          a_d     = rd_parent_i;
          steps_d = steps_q + 1'b1;
          diff_d  = diff_q - 1'b1;
        end
      end
      lpc_pkg::DP_CLIMB_A: begin
        if (!budget) begin
          a_d     = rd_parent_i;
          steps_d = steps_q + 1'b1;
        end
      end
      lpc_pkg::DP_CLIMB_B: begin
        if (!budget) begin
          b_d     = rd_parent_i;
          steps_d = steps_q + 1'b1;
        end
      end
      lpc_pkg::DP_EMIT_OK: begin
        if (!out_full) begin
          out_d       = '{ancestor: a_q, fault: 1'b0};
          out_valid_d = 1'b1;
        end
      end
      lpc_pkg::DP_EMIT_FAIL: begin
        if (!out_full) begin
          out_d       = '{ancestor: '0, fault: 1'b1};
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    da_q    <= da_d;
    diff_q  <= diff_d;
    steps_q <= steps_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* design/lpc_sequencer.sv */
// ----------------------------------------------------------------------------
// lpc_sequencer: microprogram step counter
// Fetches the control word for the current step and picks the next step
// from the jump condition.
// ----------------------------------------------------------------------------
module lpc_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lpc_pkg::status_t status_i,
  output lpc_pkg::ctrl_t   ctrl_o
);

  logic [lpc_pkg::UpcW-1:0] upc_q, upc_d;
  logic                     take;

  assign ctrl_o = lpc_pkg::ucode(upc_q);

  always_comb begin
    case (ctrl_o.cond)
      lpc_pkg::CND_NEVER:     take = 1'b0;
      lpc_pkg::CND_CLEARING:  take = status_i.clearing;
      lpc_pkg::CND_NO_QUERY:  take = status_i.no_query;
      lpc_pkg::CND_A_EQ_B:    take = status_i.a_eq_b;
      lpc_pkg::CND_DIFF_ZERO: take = status_i.diff_zero;
      lpc_pkg::CND_BUDGET:    take = status_i.budget;
      lpc_pkg::CND_OUT_FULL:  take = status_i.out_full;
      default:                take = 1'b0;
    endcase
    upc_d = take ? ctrl_o.jmp : ctrl_o.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= lpc_pkg::StClr;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

/* design/lca_parent_climb.sv */
// ----------------------------------------------------------------------------
// lca_parent_climb: lowest common ancestor by climbing a parent table
// Writes: a table write takes one idle-step transfer and no result. A query
//   with equal nodes goes from the compare step straight to the emit step;
//   otherwise a climbs to b's depth, then a and b climb in turn through the
//   single read port of the node table, up to a budget of Nodes climbs.
// Throughput: one item at a time; the next transfer is taken once the result
//   is registered, while that result may still wait downstream.
// Reset: a clearing pass zeroes every entry of the node table; inputs stall.
// ----------------------------------------------------------------------------
module lca_parent_climb (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpc_pkg::in_item_t   in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpc_pkg::out_item_t  out_o
);

  // Control word from the microprogram and the conditions it branches on.
  lpc_pkg::ctrl_t    ctrl;
  lpc_pkg::status_t  status;
  lpc_pkg::mem_req_t req;

  logic [lpc_pkg::IdW-1:0] rd_parent, rd_depth;
  logic                    clearing;

  // Step counter walks the fixed program: clear, idle, equality check, depth compare,
  // equalize depths, paired climb, emit.
  lpc_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Node table: writes come from write transfers and the clearing pass, reads follow node a or b.
  lpc_node_mem u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rd_parent_o (rd_parent),
    .rd_depth_o  (rd_depth),
    .clearing_o  (clearing)
  );

  // Climb registers, step budget and result register.
  lpc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .out_stall_i (out_stall_i),
    .rd_parent_i (rd_parent),
    .rd_depth_i  (rd_depth),
    .clearing_i  (clearing),
    .req_o       (req),
    .status_o    (status),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  // No input transfer while the table is still being cleared.
  a_no_xfer_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> in_stall_o)
    else $error("input taken during clearing pass");

  // A query transfer occupies the block on the next cycle.
  a_query_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_i.opcode == lpc_pkg::OpQuery)) |=> in_stall_o)
    else $error("query transfer did not start a climb");

  // An emit step with room in the result register must present a result.
  a_emit_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ctrl.op == lpc_pkg::DP_EMIT_OK || ctrl.op == lpc_pkg::DP_EMIT_FAIL)
     && !status.out_full) |=> out_valid_o)
    else $error("emitted result lost");

  // Leaving an emit step always returns to the idle step.
  a_emit_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ctrl.op == lpc_pkg::DP_EMIT_OK || ctrl.op == lpc_pkg::DP_EMIT_FAIL)
     && !status.out_full) |=> (ctrl.op == lpc_pkg::DP_LOAD_QUERY))
    else $error("sequencer did not return to idle after emit");

endmodule
